/* hdl/frwh_pkg.sv */
// ----------------------------------------------------------------------------
// frwh_pkg
// Shared types and constants for the regression forest core.
// ----------------------------------------------------------------------------
package frwh_pkg;

   localparam int MAX_TREES   = 64;
   localparam int MAX_NODES   = 256;
   localparam int MAX_TAPS    = 8;
   localparam int MAX_SPACING = 16;
   localparam int MAX_DEPTH   = 32;
   localparam int HIST_LEN    = MAX_TAPS * MAX_SPACING;
   localparam int NUM_FEATS   = 3 * MAX_TAPS;

   localparam int TREE_W  = $clog2(MAX_TREES);
   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int HADDR_W = $clog2(HIST_LEN);
   localparam int FEAT_W  = 5;
   localparam int DATA_W  = 32;
   localparam int SUM_W   = DATA_W + TREE_W;
   localparam int DIVC_W  = $clog2(SUM_W);
   localparam int STEP_W  = $clog2(MAX_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_PUSH    = 2'd1,
      CMD_PREDICT = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_FORCE_TAPS = 3'd0,
      REG_VEL_TAPS   = 3'd1,
      REG_PRED_TAPS  = 3'd2,
      REG_SPACING    = 3'd3,
      REG_TREES      = 3'd4,
      REG_NOISE      = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [3:0] force_taps;
      logic [3:0] vel_taps;
      logic [3:0] pred_taps;
      logic [4:0] spacing;
      logic [6:0] trees;
      logic       noise_on;
   } cfg_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [TREE_W-1:0]  tree;
      logic [NODE_W-1:0]  node;
      logic [NODE_W-1:0]  left;
      logic [NODE_W-1:0]  right;
      logic [FEAT_W-1:0]  feat;
      logic               leaf;
      logic [DATA_W-1:0]  value;
      logic [DATA_W-1:0]  force_s;
      logic [DATA_W-1:0]  vel_s;
      logic [DATA_W-1:0]  noise_s;
   } item_type;

   typedef struct packed {
      logic [NODE_W-1:0] left;
      logic [NODE_W-1:0] right;
      logic [FEAT_W-1:0] feat;
      logic              leaf;
      logic [DATA_W-1:0] value;
   } node_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GATHER_RD,
      ST_GATHER_WR,
      ST_WALK_RD,
      ST_WALK_EV,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

/* hdl/forest_regression_with_history_core.sv */
// ----------------------------------------------------------------------------
// forest_regression_with_history_core
// Regression forest over delayed force, velocity and prediction histories.
// ----------------------------------------------------------------------------
// Load and push requests are carried out directly from the idle state of the
// back end. A predict request gathers the configured taps into a feature
// vector and then walks every tree: the node store has one registered read
// port, so each node visit passes through a read state and an evaluate
// state, and the tree average runs through a bit-serial divider of 38 steps.
// A two-entry queue in front lets new requests be taken while a predict runs.
module forest_regression_with_history_core
   import frwh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_command,
   input  logic [5:0]   req_tree_number,
   input  logic [7:0]   req_node_number,
   input  logic [7:0]   req_left_child,
   input  logic [7:0]   req_right_child,
   input  logic [4:0]   req_feature_select,
   input  logic         req_leaf_flag,
   input  logic [31:0]  req_node_value,
   input  logic [31:0]  req_force_sample,
   input  logic [31:0]  req_velocity_sample,
   input  logic [31:0]  req_noise_sample,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [31:0]  rsp_prediction,
   output logic         rsp_depth_overrun,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [6:0]   csr_wdata
);

   logic [3:0] ft_ff, ft_in, vt_ff, vt_in, pt_ff, pt_in;
   logic [4:0] sp_ff, sp_in;
   logic [6:0] tc_ff, tc_in;
   logic       nz_ff, nz_in;
   cfg_type    cfg;
   item_type   req_item, q_item;
   logic       q_valid, q_pop;

   always_comb begin
      ft_in = ft_ff;
      vt_in = vt_ff;
      pt_in = pt_ff;
      sp_in = sp_ff;
      tc_in = tc_ff;
      nz_in = nz_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_FORCE_TAPS: ft_in = csr_wdata[3:0];
            REG_VEL_TAPS:   vt_in = csr_wdata[3:0];
            REG_PRED_TAPS:  pt_in = csr_wdata[3:0];
            REG_SPACING:    sp_in = csr_wdata[4:0];
            REG_TREES:      tc_in = csr_wdata;
            REG_NOISE:      nz_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ft_ff <= '0;
         vt_ff <= '0;
         pt_ff <= '0;
         sp_ff <= 5'd1;
         tc_ff <= 7'd1;
         nz_ff <= 1'b0;
      end else begin
         ft_ff <= ft_in;
         vt_ff <= vt_in;
         pt_ff <= pt_in;
         sp_ff <= sp_in;
         tc_ff <= tc_in;
         nz_ff <= nz_in;
      end
   end

   always_comb begin
      cfg.force_taps = (ft_ff > 4'(MAX_TAPS)) ? 4'(MAX_TAPS) : ft_ff;
      cfg.vel_taps   = (vt_ff > 4'(MAX_TAPS)) ? 4'(MAX_TAPS) : vt_ff;
      cfg.pred_taps  = (pt_ff > 4'(MAX_TAPS)) ? 4'(MAX_TAPS) : pt_ff;
      cfg.spacing    = (sp_ff == '0) ? 5'd1 :
                       (sp_ff > 5'(MAX_SPACING)) ? 5'(MAX_SPACING) : sp_ff;
      cfg.trees      = (tc_ff == '0) ? 7'd1 :
                       (tc_ff > 7'(MAX_TREES)) ? 7'(MAX_TREES) : tc_ff;
      cfg.noise_on   = nz_ff;
   end

   always_comb begin
      req_item.cmd     = cmd_type'(req_command);
      req_item.tree    = req_tree_number;
      req_item.node    = req_node_number;
      req_item.left    = req_left_child;
      req_item.right   = req_right_child;
      req_item.feat    = req_feature_select;
      req_item.leaf    = req_leaf_flag;
      req_item.value   = req_node_value;
      req_item.force_s = req_force_sample;
      req_item.vel_s   = req_velocity_sample;
      req_item.noise_s = req_noise_sample;
   end

   frwh_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_item  (req_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_item   (q_item)
   );

   frwh_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_item         (q_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_prediction (rsp_prediction),
      .rsp_overrun    (rsp_depth_overrun)
   );

endmodule

/* hdl/frwh_front.sv */
// ----------------------------------------------------------------------------
// frwh_front
// Request intake: classify commands, drop CMD_NONE ones, two-entry queue.
// ----------------------------------------------------------------------------
module frwh_front
   import frwh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     q_valid,
   input  logic     q_pop,
   output item_type q_item
);

   item_type   slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready && (in_item.cmd != CMD_NONE);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ q_pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= in_item;
      end
   end

endmodule

/* hdl/frwh_engine.sv */
// ----------------------------------------------------------------------------
// frwh_engine
// Back end: node store, histories, tree walks, averaging and result register.
// ----------------------------------------------------------------------------
module frwh_engine
   import frwh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              q_valid,
   output logic              q_pop,
   input  item_type          q_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_prediction,
   output logic              rsp_overrun
);

   node_type          node_mem [MAX_TREES*MAX_NODES];
   logic [DATA_W-1:0] fh_mem [HIST_LEN];
   logic [DATA_W-1:0] vh_mem [HIST_LEN];
   logic [DATA_W-1:0] ph_mem [HIST_LEN];
   logic [DATA_W-1:0] feat_ff [NUM_FEATS];

   state_type state_ff, state_in;

   node_type          node_rd_ff;
   logic [DATA_W-1:0] fh_rd_ff, vh_rd_ff, ph_rd_ff;

   logic [HADDR_W-1:0] fv_wp_ff, fv_wp_in, p_wp_ff, p_wp_in;
   logic [HADDR_W:0]   fv_cnt_ff, fv_cnt_in, p_cnt_ff, p_cnt_in;

   logic [1:0]        src_ff, src_in;
   logic [3:0]        tap_ff, tap_in;
   logic [HADDR_W:0]  pos_ff, pos_in;
   logic [FEAT_W-1:0] fidx_ff, fidx_in;
   logic              zero_ff, zero_in;

   logic [TREE_W-1:0] t_ff, t_in;
   logic [NODE_W-1:0] k_ff, k_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic              ovr_ff, ovr_in;

   logic [SUM_W-1:0]  dvd_ff, dvd_in;
   logic [6:0]        rem_ff, rem_in;
   logic [DIVC_W-1:0] dcnt_ff, dcnt_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] noise_ff, noise_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_pred_ff, rsp_pred_in;
   logic              rsp_ovr_ff, rsp_ovr_in;

   logic              node_we, fv_we, p_we, feat_we;
   logic [DATA_W-1:0] p_wd, feat_wd;
   logic [4:0]        total;
   logic [3:0]        n_sel;
   logic [HADDR_W:0]  cnt_sel;
   logic signed [DATA_W-1:0] x_val;
   logic [7:0]        rem_sh;
   logic signed [SUM_W:0]   q_s;
   logic signed [SUM_W+1:0] res;
   logic [HADDR_W-1:0] fv_ra, p_ra;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prediction = rsp_pred_ff;
   assign rsp_overrun    = rsp_ovr_ff;

   assign total  = {1'b0, cfg.force_taps} + {1'b0, cfg.vel_taps} + {1'b0, cfg.pred_taps};
   assign fv_ra  = fv_wp_ff - pos_ff[HADDR_W-1:0];
   assign p_ra   = p_wp_ff - pos_ff[HADDR_W-1:0];
   assign rem_sh = {rem_ff, dvd_ff[SUM_W-1]};

   always_comb begin
      unique case (src_ff)
         2'd0:    begin n_sel = cfg.force_taps; cnt_sel = fv_cnt_ff; end
         2'd1:    begin n_sel = cfg.vel_taps;   cnt_sel = fv_cnt_ff; end
         default: begin n_sel = cfg.pred_taps;  cnt_sel = p_cnt_ff;  end
      endcase
   end

   always_comb begin
      x_val = '0;
      if ({1'b0, node_rd_ff.feat} < {1'b0, total}) begin
         x_val = $signed(feat_ff[node_rd_ff.feat]);
      end
      q_s = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});
      res = (SUM_W+2)'(q_s);
      if (cfg.noise_on) begin
         res = res + (SUM_W+2)'($signed(noise_ff));
      end
   end

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      node_we      = 1'b0;
      fv_we        = 1'b0;
      p_we         = 1'b0;
      p_wd         = '0;
      feat_we      = 1'b0;
      feat_wd      = '0;
      fv_wp_in     = fv_wp_ff;
      fv_cnt_in    = fv_cnt_ff;
      p_wp_in      = p_wp_ff;
      p_cnt_in     = p_cnt_ff;
      src_in       = src_ff;
      tap_in       = tap_ff;
      pos_in       = pos_ff;
      fidx_in      = fidx_ff;
      zero_in      = zero_ff;
      t_in         = t_ff;
      k_in         = k_ff;
      steps_in     = steps_ff;
      sum_in       = sum_ff;
      ovr_in       = ovr_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      neg_in       = neg_ff;
      noise_in     = noise_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pred_in  = rsp_pred_ff;
      rsp_ovr_in   = rsp_ovr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_item.cmd)
                  CMD_LOAD: node_we = 1'b1;
                  CMD_PUSH: begin
                     fv_we    = 1'b1;
                     fv_wp_in = fv_wp_ff + 1'b1;
                     if (fv_cnt_ff != (HADDR_W+1)'(HIST_LEN)) begin
                        fv_cnt_in = fv_cnt_ff + 1'b1;
                     end
                  end
                  CMD_PREDICT: begin
                     noise_in = q_item.noise_s;
                     src_in   = 2'd0;
                     tap_in   = '0;
                     pos_in   = (HADDR_W+1)'(cfg.spacing) - 1'b1;
                     fidx_in  = '0;
                     state_in = ST_GATHER_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_GATHER_RD: begin
            if (src_ff == 2'd3) begin
               t_in     = '0;
               k_in     = '0;
               steps_in = '0;
               sum_in   = '0;
               ovr_in   = 1'b0;
               state_in = ST_WALK_RD;
            end else if (tap_ff < n_sel) begin
               zero_in  = (pos_ff >= cnt_sel);
               state_in = ST_GATHER_WR;
            end else begin
               src_in = src_ff + 1'b1;
               tap_in = '0;
               pos_in = (HADDR_W+1)'(cfg.spacing) - 1'b1;
            end
         end
         ST_GATHER_WR: begin
            feat_we = 1'b1;
            unique case (src_ff)
               2'd0:    feat_wd = fh_rd_ff;
               2'd1:    feat_wd = vh_rd_ff;
               default: feat_wd = ph_rd_ff;
            endcase
            if (zero_ff) begin
               feat_wd = '0;
            end
            fidx_in  = fidx_ff + 1'b1;
            tap_in   = tap_ff + 1'b1;
            pos_in   = pos_ff + (HADDR_W+1)'(cfg.spacing);
            state_in = ST_GATHER_RD;
         end
         ST_WALK_RD: state_in = ST_WALK_EV;
         ST_WALK_EV: begin
            if (node_rd_ff.leaf || steps_ff == STEP_W'(MAX_DEPTH)) begin
               if (node_rd_ff.leaf) begin
                  sum_in = sum_ff + SUM_W'($signed(node_rd_ff.value));
               end else begin
                  ovr_in = 1'b1;
               end
               if (({1'b0, t_ff} + 1'b1) == cfg.trees) begin
                  neg_in   = sum_in < 0;
                  dvd_in   = (sum_in < 0) ? SUM_W'(-sum_in) : SUM_W'(sum_in);
                  rem_in   = '0;
                  dcnt_in  = '0;
                  state_in = ST_DIVIDE;
               end else begin
                  t_in     = t_ff + 1'b1;
                  k_in     = '0;
                  steps_in = '0;
                  state_in = ST_WALK_RD;
               end
            end else begin
               k_in     = (x_val <= $signed(node_rd_ff.value)) ? node_rd_ff.left
                                                              : node_rd_ff.right;
               steps_in = steps_ff + 1'b1;
               state_in = ST_WALK_RD;
            end
         end
         ST_DIVIDE: begin
            if (rem_sh >= {1'b0, cfg.trees}) begin
               rem_in = 7'(rem_sh - {1'b0, cfg.trees});
               dvd_in = {dvd_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[6:0];
               dvd_in = {dvd_ff[SUM_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DIVC_W'(SUM_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (res > (SUM_W+2)'(32'sh7FFF_FFFF)) begin
                  p_wd = 32'h7FFF_FFFF;
               end else if (res < -(SUM_W+2)'(33'sh0_8000_0000)) begin
                  p_wd = 32'h8000_0000;
               end else begin
                  p_wd = res[DATA_W-1:0];
               end
               p_we         = 1'b1;
               p_wp_in      = p_wp_ff + 1'b1;
               if (p_cnt_ff != (HADDR_W+1)'(HIST_LEN)) begin
                  p_cnt_in = p_cnt_ff + 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_pred_in  = p_wd;
               rsp_ovr_in   = ovr_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fv_wp_ff     <= '0;
         fv_cnt_ff    <= '0;
         p_wp_ff      <= '0;
         p_cnt_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fv_wp_ff     <= fv_wp_in;
         fv_cnt_ff    <= fv_cnt_in;
         p_wp_ff      <= p_wp_in;
         p_cnt_ff     <= p_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      tap_ff      <= tap_in;
      pos_ff      <= pos_in;
      fidx_ff     <= fidx_in;
      zero_ff     <= zero_in;
      t_ff        <= t_in;
      k_ff        <= k_in;
      steps_ff    <= steps_in;
      sum_ff      <= sum_in;
      ovr_ff      <= ovr_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      neg_ff      <= neg_in;
      noise_ff    <= noise_in;
      rsp_pred_ff <= rsp_pred_in;
      rsp_ovr_ff  <= rsp_ovr_in;
   end

   always_ff @(posedge clock) begin
      if (feat_we) begin
         feat_ff[fidx_ff] <= feat_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[{q_item.tree, q_item.node}] <= '{left:  q_item.left,
                                                   right: q_item.right,
                                                   feat:  q_item.feat,
                                                   leaf:  q_item.leaf,
                                                   value: q_item.value};
      end
      node_rd_ff <= node_mem[{t_ff, k_ff}];
   end

   always_ff @(posedge clock) begin
      if (fv_we) begin
         fh_mem[fv_wp_in] <= q_item.force_s;
         vh_mem[fv_wp_in] <= q_item.vel_s;
      end
      fh_rd_ff <= fh_mem[fv_ra];
      vh_rd_ff <= vh_mem[fv_ra];
   end

   always_ff @(posedge clock) begin
      if (p_we) begin
         ph_mem[p_wp_in] <= p_wd;
      end
      ph_rd_ff <= ph_mem[p_ra];
   end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Regression forest core testbench
// Loads tree nodes, pushes force and velocity samples and runs predictions
// under several register settings. A scoreboard keeps its own copy of the
// node store, the three histories and the registers, works out every
// prediction and checks the responses in order. Both channels stall at
// random, and predictions are only issued when every node that they reach
// has been loaded.
// ----------------------------------------------------------------------------
module testbench;
   import frwh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   class forest_scoreboard;
      logic [7:0]  node_left   [MAX_TREES*MAX_NODES];
      logic [7:0]  node_right  [MAX_TREES*MAX_NODES];
      logic [4:0]  node_feat   [MAX_TREES*MAX_NODES];
      bit          node_leaf   [MAX_TREES*MAX_NODES];
      int          node_val    [MAX_TREES*MAX_NODES];
      bit          node_loaded [MAX_TREES*MAX_NODES];
      int          force_hist [HIST_LEN];
      int          vel_hist   [HIST_LEN];
      int          pred_hist  [HIST_LEN];
      longint      feat_vec   [NUM_FEATS];
      int unsigned reg_val [6];
      int          want_pred [$];
      bit          want_ovr  [$];
      int          errors, n_load, n_push, n_pred, n_ovr, n_idle;

      function new();
         reg_val = '{0, 0, 0, 1, 1, 0};
         foreach (force_hist[i]) begin
            force_hist[i] = 0;
            vel_hist[i] = 0;
            pred_hist[i] = 0;
         end
         foreach (node_loaded[i]) node_loaded[i] = 0;
      endfunction

      function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
         return (v < lo) ? lo : (v > hi) ? hi : v;
      endfunction

      function int unsigned tree_total();
         return clip(reg_val[REG_TREES], 1, MAX_TREES);
      endfunction

      function int unsigned feat_total();
         return clip(reg_val[REG_FORCE_TAPS], 0, MAX_TAPS) + clip(reg_val[REG_VEL_TAPS], 0,
            MAX_TAPS) + clip(reg_val[REG_PRED_TAPS], 0, MAX_TAPS);
      endfunction

      function void build_features();
         int unsigned nf, nv, np, sp;
         nf = clip(reg_val[REG_FORCE_TAPS], 0, MAX_TAPS);
         nv = clip(reg_val[REG_VEL_TAPS], 0, MAX_TAPS);
         np = clip(reg_val[REG_PRED_TAPS], 0, MAX_TAPS);
         sp = clip(reg_val[REG_SPACING], 1, MAX_SPACING);
         for (int i = 0; i < nf; i++) feat_vec[i] = force_hist[(i+1)*sp-1];
         for (int i = 0; i < nv; i++) feat_vec[nf+i] = vel_hist[(i+1)*sp-1];
         for (int i = 0; i < np; i++) feat_vec[nf+nv+i] = pred_hist[(i+1)*sp-1];
      endfunction

      // 0: leaf reached, 1: too deep, 2: hit a node never loaded (node gives the address)
      function int walk_tree(int t, output int node, output int leaf_val);
         int     k, base, steps;
         longint x;
         base = t * MAX_NODES;
         k = 0;
         steps = 0;
         leaf_val = 0;
         forever begin
            node = base + k;
            if (!node_loaded[node]) return 2;
            if (node_leaf[node]) begin
               leaf_val = node_val[node];
               return 0;
            end
            if (steps >= MAX_DEPTH) return 1;
            x = (node_feat[node] < feat_total()) ? feat_vec[node_feat[node]] : 0;
            k = (x <= longint'(node_val[node])) ? node_left[node] : node_right[node];
            steps++;
         end
      endfunction

      // address of the first unloaded node that a predict would read, or -1
      function int missing_node();
         int node, lv;
         build_features();
         for (int t = 0; t < tree_total(); t++)
            if (walk_tree(t, node, lv) == 2) return node;
         return -1;
      endfunction

      function void set_reg(reg_index_type idx, int unsigned v);
         reg_val[idx] = v;
      endfunction

      function void note_request(item_type it);
         int     node, lv, st;
         longint sum, res;
         bit     ovr;
         case (it.cmd)
            CMD_LOAD: begin
               node = it.tree * MAX_NODES + it.node;
               node_left[node] = it.left;
               node_right[node] = it.right;
               node_feat[node] = it.feat;
               node_leaf[node] = it.leaf;
               node_val[node] = it.value;
               node_loaded[node] = 1;
               n_load++;
            end
            CMD_PUSH: begin
               for (int i = HIST_LEN-1; i > 0; i--) begin
                  force_hist[i] = force_hist[i-1];
                  vel_hist[i] = vel_hist[i-1];
               end
               force_hist[0] = it.force_s;
               vel_hist[0] = it.vel_s;
               n_push++;
            end
            CMD_PREDICT: begin
               build_features();
               sum = 0;
               ovr = 0;
               for (int t = 0; t < tree_total(); t++) begin
                  st = walk_tree(t, node, lv);
                  if (st == 0) sum += lv;
                  else ovr = 1;
               end
               res = sum / longint'(tree_total());
               if (reg_val[REG_NOISE][0]) res += longint'(signed'(it.noise_s));
               if (res > 64'sh7fffffff) res = 64'sh7fffffff;
               if (res < -64'sh80000000) res = -64'sh80000000;
               for (int i = HIST_LEN-1; i > 0; i--) pred_hist[i] = pred_hist[i-1];
               pred_hist[0] = int'(res);
               want_pred = {want_pred, int'(res)};
               want_ovr = {want_ovr, ovr};
               n_pred++;
               n_ovr += ovr;
            end
            default: n_idle++;
         endcase
      endfunction

      function void check_response(logic [31:0] p, logic o);
         int ep;
         bit eo;
         if (want_pred.size() == 0) begin
            $display("%0t: unexpected response expected none actual %h/%b", $time, p, o);
            errors++;
            return;
         end
         ep = want_pred.pop_front();
         eo = want_ovr.pop_front();
         if (p !== ep) begin
            $display("%0t: prediction expected %h actual %h", $time, ep, p);
            errors++;
         end
         if (o !== eo) begin
            $display("%0t: depth_overrun expected %b actual %b", $time, eo, o);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_command;
   logic [5:0]  req_tree_number;
   logic [7:0]  req_node_number, req_left_child, req_right_child;
   logic [4:0]  req_feature_select;
   logic        req_leaf_flag;
   logic [31:0] req_node_value, req_force_sample, req_velocity_sample, req_noise_sample;
   logic        rsp_valid, rsp_ready;
   logic [31:0] rsp_prediction;
   logic        rsp_depth_overrun;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [6:0]  csr_wdata;

   forest_scoreboard forest_sb;
   bit               calm;

   forest_regression_with_history_core u_dut (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function int unsigned pick_gap();
      return calm ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16));
   endfunction

   function logic [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom_range(0, 8) * 32'h8000 - 32'h20000;
      endcase
   endfunction

   function automatic item_type random_item();
      logic [191:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return raw[$bits(item_type)-1:0];
   endfunction

   task automatic send_request(item_type it);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command = it.cmd;
      req_tree_number = it.tree;
      req_node_number = it.node;
      req_left_child = it.left;
      req_right_child = it.right;
      req_feature_select = it.feat;
      req_leaf_flag = it.leaf;
      req_node_value = it.value;
      req_force_sample = it.force_s;
      req_velocity_sample = it.vel_s;
      req_noise_sample = it.noise_s;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      forest_sb.note_request(it);
      @(negedge clock);
   endtask

   task automatic load_node(int t, int n, int l, int r, int f, bit leaf, logic [31:0] v);
      item_type it;
      it = random_item();
      it.cmd = CMD_LOAD;
      it.tree = TREE_W'(t);
      it.node = NODE_W'(n);
      it.left = NODE_W'(l);
      it.right = NODE_W'(r);
      it.feat = FEAT_W'(f);
      it.leaf = leaf;
      it.value = v;
      send_request(it);
   endtask

   task automatic push_samples(logic [31:0] fs, logic [31:0] vs);
      item_type it;
      it = random_item();
      it.cmd = CMD_PUSH;
      it.force_s = fs;
      it.vel_s = vs;
      send_request(it);
   endtask

   // fill in unloaded nodes on the path first, then predict
   task automatic predict(logic [31:0] noise);
      item_type it;
      int       gap_node;
      gap_node = forest_sb.missing_node();
      while (gap_node >= 0) begin
         load_node(gap_node / MAX_NODES, gap_node % MAX_NODES,
            $urandom_range(0, 9) ? $urandom_range(0, 15) : $urandom_range(0, 255),
            $urandom_range(0, 9) ? $urandom_range(0, 15) : $urandom_range(0, 255),
            $urandom_range(0, 31), $urandom_range(0, 4) < 2, pick_value());
         gap_node = forest_sb.missing_node();
      end
      it = random_item();
      it.cmd = CMD_PREDICT;
      it.noise_s = noise;
      send_request(it);
   endtask

   task automatic write_reg(reg_index_type idx, int unsigned v);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = 7'(v);
      forest_sb.set_reg(idx, v);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (forest_sb.want_pred.size() != 0) @(negedge clock);
      repeat (4500) @(negedge clock);
   endtask

   initial begin
      forest_sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_FORCE_TAPS;
      csr_wdata = '0;
      {req_command, req_tree_number, req_node_number, req_left_child, req_right_child,
         req_feature_select, req_leaf_flag, req_node_value, req_force_sample,
         req_velocity_sample, req_noise_sample} = '0;
      calm = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      write_reg(REG_FORCE_TAPS, 2);
      write_reg(REG_VEL_TAPS, 2);
      write_reg(REG_PRED_TAPS, 2);
      write_reg(REG_SPACING, 1);
      write_reg(REG_TREES, 3);
      write_reg(REG_NOISE, 1);
      load_node(0, 0, 1, 2, 0, 0, 32'h0);
      load_node(0, 1, 0, 0, 0, 1, 32'h7fffffff);
      load_node(0, 2, 0, 0, 0, 1, 32'h80000000);
      load_node(1, 0, 255, 255, 31, 0, 32'h80000000);
      load_node(1, 255, 0, 0, 0, 1, 32'h7fffffff);
      load_node(2, 0, 0, 0, 4, 0, 32'h0);
      predict(32'h7fffffff);
      push_samples(32'h7fffffff, 32'h80000000);
      predict(32'h80000000);
      push_samples(32'h80000000, 32'h7fffffff);
      push_samples(32'h0, 32'h0);
      predict(32'h1);
      load_node(2, 0, 0, 0, 0, 1, 32'hffffffff);
      predict(32'h0);
      load_node(63, 255, 255, 255, 31, 1, 32'hffffffff);
      begin
         item_type it;
         it = random_item();
         it.cmd = CMD_NONE;
         send_request(it);
      end
      predict($urandom);

      for (int ph = 0; ph < 9; ph++) begin
         drain();
         calm = (ph % 3 == 2);
         case (ph)
            0: begin
               write_reg(REG_FORCE_TAPS, 15);
               write_reg(REG_VEL_TAPS, 8);
               write_reg(REG_PRED_TAPS, 15);
               write_reg(REG_SPACING, 31);
               write_reg(REG_TREES, 127);
               write_reg(REG_NOISE, 0);
            end
            1: begin
               write_reg(REG_FORCE_TAPS, 0);
               write_reg(REG_VEL_TAPS, 0);
               write_reg(REG_PRED_TAPS, 0);
               write_reg(REG_SPACING, 0);
               write_reg(REG_TREES, 0);
               write_reg(REG_NOISE, 1);
            end
            2: begin
               write_reg(REG_FORCE_TAPS, 8);
               write_reg(REG_VEL_TAPS, 8);
               write_reg(REG_PRED_TAPS, 8);
               write_reg(REG_SPACING, 16);
               write_reg(REG_TREES, 64);
            end
            default: begin
               write_reg(REG_FORCE_TAPS, $urandom_range(0, 15));
               write_reg(REG_VEL_TAPS, $urandom_range(0, 15));
               write_reg(REG_PRED_TAPS, $urandom_range(0, 15));
               write_reg(REG_SPACING, $urandom_range(0, 31));
               write_reg(REG_TREES, $urandom_range(0, 1) ? $urandom_range(0, 8) :
                  $urandom_range(0, 127));
               write_reg(REG_NOISE, $urandom_range(0, 1));
            end
         endcase
         for (int n = 0; n < 45; n++) begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7:
                  push_samples(pick_value(), pick_value());
               8, 9, 10, 11, 12, 13:
                  predict(pick_value());
               14, 15, 16, 17, 18:
                  load_node($urandom_range(0, 4) ? $urandom_range(0, forest_sb.tree_total()-1)
                     : $urandom_range(0, 63), $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom_range(0, 3) ? $urandom_range(0, 15) :
                     $urandom_range(0, 255), $urandom_range(0, 31),
                     $urandom_range(0, 4) < 2, pick_value());
               default: begin
                  item_type it;
                  it = random_item();
                  it.cmd = CMD_NONE;
                  send_request(it);
               end
            endcase
         end
      end
      drain();

      $display("covered %0d loads, %0d pushes, %0d ignored requests", forest_sb.n_load,
         forest_sb.n_push, forest_sb.n_idle);
      $display("checked %0d predictions, %0d with a too-deep walk", forest_sb.n_pred,
         forest_sb.n_ovr);
      if (forest_sb.errors == 0) begin
         $display("forest_regression_with_history_core regression: pass");
      end else begin
         $display("forest_regression_with_history_core regression: fail");
      end
      $finish;
   end

   initial begin
      int unsigned stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         forest_sb.check_response(rsp_prediction, rsp_depth_overrun);
         @(negedge clock);
      end
   end

   initial begin
      #300ms;
      $display("forest_regression_with_history_core regression: fail");
      $finish;
   end

endmodule
